FILE: design/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// implication after a fixed number of cycles
`define ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");

`endif

FILE: design/lpm_pkg.sv
// shared types and constants of the lattice membership pipeline
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int LAT_TYPE_BITS  = 4;

    typedef enum logic [LAT_TYPE_BITS-1:0] {
        LAT_SC          = 4'd0,
        LAT_FCC         = 4'd1,
        LAT_BCC         = 4'd2,
        LAT_HCP         = 4'd3,
        LAT_RH_DODEC    = 4'd4,
        LAT_CUBO_OCT    = 4'd5,
        LAT_TR_OCT      = 4'd6,
        LAT_TR_TET      = 4'd7,
        LAT_MIXED       = 4'd8,
        LAT_DIAMOND     = 4'd9,
        LAT_HCP_DIAMOND = 4'd10,
        LAT_K4          = 4'd11
    } lattice_t;

    // mod 9 by chunk sums: 2^6 is 1 mod 9
    localparam int CHUNK_BITS = 6;
    localparam int MOD9       = 9;
    localparam int MOD9_RECIP = 57;   // floor(v*57/512) == v/9 for v < 512
    localparam int MOD9_SHIFT = 9;
    localparam int NEG_FIX    = 8;    // -1 mod 9, undoes the sign-extension weight

    typedef struct packed {
        logic [3:0] mod9;
        logic [1:0] low;
        logic       neg;
    } coord_res_t;

    typedef struct packed {
        logic       neg;
        logic [2:0] low;
    } sum_res_t;

    // hcp diamond offsets (0,0,0) (3,3,3) (6,0,6) (9,3,9): their sums mod 8 and mod 9
    localparam logic [2:0] HCPD_SUM_MOD8 [4] = '{3'd0, 3'd1, 3'd4, 3'd5};
    localparam logic [3:0] HCPD_SUM_MOD9 [4] = '{4'd0, 4'd0, 4'd3, 4'd3};

    // k4 residue triples {a, b, c}
    localparam logic [5:0] K4_PAT [8] = '{
        6'b00_00_00, 6'b00_01_11, 6'b01_00_01, 6'b01_01_10,
        6'b10_10_10, 6'b10_11_01, 6'b11_10_11, 6'b11_11_00
    };

endpackage

`default_nettype wire

FILE: design/lpm_residue.sv
// two-stage mod 9 residue unit for one coordinate
`timescale 1ns / 1ps
`default_nettype none

module lpm_residue #(
    parameter int COORD_BITS = lpm_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic signed [COORD_BITS-1:0] coord,
    output lpm_pkg::coord_res_t               res
);

    localparam int CHUNKS    = (COORD_BITS + lpm_pkg::CHUNK_BITS - 1) / lpm_pkg::CHUNK_BITS;
    localparam int PAD_BITS  = CHUNKS * lpm_pkg::CHUNK_BITS;
    localparam int SUM_BITS  = $clog2(CHUNKS * ((1 << lpm_pkg::CHUNK_BITS) - 1)
                                      + lpm_pkg::NEG_FIX + 1);
    localparam int PROD_BITS = SUM_BITS + 6;

    logic signed [PAD_BITS-1:0] padded;
    logic [SUM_BITS-1:0]        acc_next, acc_reg;
    logic [1:0]                 low_reg;
    logic                       neg_reg;
    logic [PROD_BITS-1:0]       prod;
    logic [SUM_BITS-1:0]        quo;
    logic [SUM_BITS-1:0]        rem;
    lpm_pkg::coord_res_t        res_next, res_reg;

    // stage 1: chunk sum of the sign-extended word, plus the fix for a negative word
    always_comb
    begin
        padded   = PAD_BITS'(coord);
        acc_next = '0;
        for (int i = 0; i < CHUNKS; i++)
        begin
            acc_next = acc_next
                     + SUM_BITS'(padded[i*lpm_pkg::CHUNK_BITS +: lpm_pkg::CHUNK_BITS]);
        end
        if (coord[COORD_BITS-1])
        begin
            acc_next = acc_next + SUM_BITS'(lpm_pkg::NEG_FIX);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        low_reg <= coord[1:0];
        neg_reg <= coord[COORD_BITS-1];
    end

    // stage 2: reciprocal multiply and correction-free remainder
    always_comb
    begin
        prod          = PROD_BITS'(acc_reg) * PROD_BITS'(lpm_pkg::MOD9_RECIP);
        quo           = SUM_BITS'(prod >> lpm_pkg::MOD9_SHIFT);
        rem           = acc_reg - quo * SUM_BITS'(lpm_pkg::MOD9);
        res_next.mod9 = 4'(rem);
        res_next.low  = low_reg;
        res_next.neg  = neg_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: design/lpm_eval.sv
// final stage: lattice tests on residues and result register
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lpm_eval (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                valid,
    input  wire lpm_pkg::lattice_t   lat_type,
    input  wire lpm_pkg::coord_res_t res_x,
    input  wire lpm_pkg::coord_res_t res_y,
    input  wire lpm_pkg::coord_res_t res_z,
    input  wire lpm_pkg::sum_res_t   sum_res,
    output logic                     done,
    output logic                     is_member
);

    function automatic logic [1:0] mod3_of9(input logic [3:0] v);
        logic [3:0] r;
        if (v >= 4'd6)
            r = v - 4'd6;
        else if (v >= 4'd3)
            r = v - 4'd3;
        else
            r = v;
        return 2'(r);
    endfunction

    function automatic logic [3:0] mod9_of27(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'd18)
            r = v - 5'd18;
        else if (v >= 5'd9)
            r = v - 5'd9;
        else
            r = v;
        return 4'(r);
    endfunction

    // |v| mod 6 folded to 0..3, from v mod 2 and v mod 3
    function automatic logic [1:0] fold6(input logic odd, input logic [1:0] m3);
        logic [1:0] r;
        unique case ({odd, m3})
            3'b0_00: r = 2'd0;
            3'b1_01: r = 2'd1;
            3'b0_10: r = 2'd2;
            3'b1_00: r = 2'd3;
            3'b0_01: r = 2'd2;
            3'b1_10: r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    logic       done_reg, member_reg;
    logic       member_next;
    logic [1:0] x2, y2, z2, x3, y3, z3;
    logic       xo, yo, zo, all_odd, all_even;
    logic [3:0] s9, am9;
    logic       m6_zero;
    logic [1:0] u, q3, target;
    logic       hcp_ok, tr_oct_ok, tr_tet_ok, mixed_ok, dia_ok, hcpd_ok, k4_ok;
    logic [1:0] fa, fb, fc;
    logic [4:0] dd;
    logic [2:0] s8;
    logic [3:0] s9i;
    logic [1:0] e3;
    logic       par;
    logic       va, vb, vc;

    always_comb
    begin
        x2 = res_x.low;
        y2 = res_y.low;
        z2 = res_z.low;
        xo = x2[0];
        yo = y2[0];
        zo = z2[0];
        x3 = mod3_of9(res_x.mod9);
        y3 = mod3_of9(res_y.mod9);
        z3 = mod3_of9(res_z.mod9);
        s9 = mod9_of27(5'(res_x.mod9) + 5'(res_y.mod9) + 5'(res_z.mod9));

        all_odd  = xo && yo && zo;
        all_even = !xo && !yo && !zo;

        // hcp: m = x+y+z, quotient m/12 truncates toward zero
        m6_zero = !sum_res.low[0] && (s9 == 4'd0 || s9 == 4'd3 || s9 == 4'd6);
        if (sum_res.neg && s9 == 4'd3)
            am9 = 4'd6;
        else if (sum_res.neg && s9 == 4'd6)
            am9 = 4'd3;
        else
            am9 = s9;
        if (!sum_res.low[1])
            u = (am9 == 4'd0) ? 2'd0 : (am9 == 4'd3) ? 2'd1 : 2'd2;
        else
            u = (am9 == 4'd6) ? 2'd0 : (am9 == 4'd0) ? 2'd1 : 2'd2;
        if (sum_res.neg)
            q3 = (u == 2'd0) ? 2'd0 : 2'd3 - u;
        else
            q3 = u;
        if (sum_res.neg)
            target = (q3 == 2'd0) ? 2'd2 : q3 - 2'd1;
        else
            target = q3;
        hcp_ok = m6_zero && x3 == target && y3 == target;

        tr_oct_ok = (z2 == 2'd0 && x2 != 2'd0 && y2 != 2'd0 && (xo ^ yo))
                 || (y2 == 2'd0 && z2 != 2'd0 && x2 != 2'd0 && (zo ^ xo))
                 || (x2 == 2'd0 && y2 != 2'd0 && z2 != 2'd0 && (yo ^ zo));

        tr_tet_ok = (!xo && y2 == 2'(x2 + z2))
                 || (!yo && z2 == 2'(y2 + x2))
                 || (!zo && x2 == 2'(z2 + y2));

        fa = fold6(xo, x3);
        fb = fold6(yo, y3);
        fc = fold6(zo, z3);
        dd = 5'(fa) * 5'(fa) + 5'(fb) * 5'(fb);
        mixed_ok = (fc == 2'd0 && (dd == 5'd2 || dd == 5'd8))
                || (fc == 2'd1 && (dd == 5'd1 || dd == 5'd13))
                || (fc == 2'd2 && (dd == 5'd4 || dd == 5'd10))
                || (fc == 2'd3 && dd == 5'd5);

        // halves with the negative-odd correction keep the parity of bit 1
        dia_ok = (all_odd || all_even) && !(x2[1] ^ y2[1] ^ z2[1]);

        // hcp diamond: each offset independently
        hcpd_ok = 1'b0;
        s8      = '0;
        s9i     = '0;
        e3      = '0;
        par     = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            par = i[0];
            s8  = sum_res.low - lpm_pkg::HCPD_SUM_MOD8[i];
            s9i = mod9_of27(5'(s9) + 5'(lpm_pkg::MOD9) - 5'(lpm_pkg::HCPD_SUM_MOD9[i]));
            e3  = (s9i == 4'd6) ? 2'd2 : (s9i == 4'd3) ? 2'd1 : 2'd0;
            if (s8 == 3'd0 && (s9i == 4'd0 || s9i == 4'd3 || s9i == 4'd6)
                && xo == par && yo == par && zo == par
                && x3 == e3 && y3 == e3 && z3 == e3)
            begin
                hcpd_ok = 1'b1;
            end
        end

        // k4: a negative multiple of four maps to residue four and never matches
        va    = !(res_x.neg && x2 == 2'd0);
        vb    = !(res_y.neg && y2 == 2'd0);
        vc    = !(res_z.neg && z2 == 2'd0);
        k4_ok = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (lpm_pkg::K4_PAT[k] == {x2, y2, z2})
            begin
                k4_ok = 1'b1;
            end
        end
        k4_ok = k4_ok && va && vb && vc && !sum_res.low[0];

        unique case (lat_type)
            lpm_pkg::LAT_SC:          member_next = 1'b1;
            lpm_pkg::LAT_FCC:         member_next = !sum_res.low[0];
            lpm_pkg::LAT_BCC:         member_next = all_odd || all_even;
            lpm_pkg::LAT_HCP:         member_next = hcp_ok;
            lpm_pkg::LAT_RH_DODEC:    member_next = all_odd || (all_even && sum_res.low[1]);
            lpm_pkg::LAT_CUBO_OCT:    member_next = ({1'b0, xo} + {1'b0, yo} + {1'b0, zo})
                                                    == 2'd2;
            lpm_pkg::LAT_TR_OCT:      member_next = tr_oct_ok;
            lpm_pkg::LAT_TR_TET:      member_next = tr_tet_ok;
            lpm_pkg::LAT_MIXED:       member_next = mixed_ok;
            lpm_pkg::LAT_DIAMOND:     member_next = dia_ok;
            lpm_pkg::LAT_HCP_DIAMOND: member_next = hcpd_ok;
            lpm_pkg::LAT_K4:          member_next = k4_ok;
            default:                  member_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        member_reg <= member_next;
    end

    assign done      = done_reg;
    assign is_member = member_reg;

    `ASSERT_NXT(a_sc_always_member, clk, rst_n, valid && lat_type == lpm_pkg::LAT_SC, done && is_member)
    `ASSERT_NXT(a_unused_type_never, clk, rst_n, valid && lat_type > lpm_pkg::LAT_K4, done && !is_member)
    `ASSERT_IMP(a_residue_range, clk, rst_n, valid, res_x.mod9 < 4'd9 && res_y.mod9 < 4'd9 && res_z.mod9 < 4'd9)

endmodule

`default_nettype wire

FILE: design/lattice_point_membership.sv
// top level of the lattice point membership pipeline
//
//  channel   | ports                           | handshake
//  ----------+---------------------------------+-----------------------------
//  point in  | coord_x, coord_y, coord_z       | start, taken when busy is low
//  result    | is_member                       | done, one-cycle strobe
//  config    | cfg_wr_data (lattice type)      | cfg_wr_en, no wait
//
//  three register stages: chunk sums, mod 9 remainder, lattice test
//  a taken word passes the v1_reg and v2_reg valid stages, then done_reg raises done with the result
//  one word per cycle sustained; busy never rises, the pipe cannot stall
//  rst_n clears the valid bits and sets the lattice type to simple cubic
//  the receiver cannot hold results off, so no stage ever waits
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lattice_point_membership #(
    parameter int COORD_BITS = lpm_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [COORD_BITS-1:0]      coord_x,
    input  wire logic signed [COORD_BITS-1:0]      coord_y,
    input  wire logic signed [COORD_BITS-1:0]      coord_z,
    input  wire logic                              cfg_wr_en,
    input  wire logic [lpm_pkg::LAT_TYPE_BITS-1:0] cfg_wr_data,
    output logic                                   done,
    output logic                                   is_member
);

    // x+y+z never overflows at two extra bits
    localparam int SUM_BITS = COORD_BITS + 2;

    logic                       accept;
    lpm_pkg::lattice_t          lat_reg;
    logic                       v1_reg, v2_reg;
    lpm_pkg::lattice_t          lat1_reg, lat2_reg;
    logic signed [SUM_BITS-1:0] sum_full;
    lpm_pkg::sum_res_t          sum1_next, sum1_reg, sum2_reg;
    lpm_pkg::coord_res_t        res_x, res_y, res_z;

    // every word is taken: the pipe has no back pressure
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // lattice type register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= lpm_pkg::LAT_SC;
        end
        else if (cfg_wr_en)
        begin
            lat_reg <= lpm_pkg::lattice_t'(cfg_wr_data);
        end
    end

    // valid bits travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // wide sum for the sign and low bits of x+y+z
    always_comb
    begin
        sum_full      = SUM_BITS'(coord_x) + SUM_BITS'(coord_y) + SUM_BITS'(coord_z);
        sum1_next.neg = sum_full[SUM_BITS-1];
        sum1_next.low = sum_full[2:0];
    end

    always_ff @(posedge clk)
    begin
        lat1_reg <= lat_reg;
        lat2_reg <= lat1_reg;
        sum1_reg <= sum1_next;
        sum2_reg <= sum1_reg;
    end

    // per-coordinate mod 9 residues, two stages each
    lpm_residue #(
        .COORD_BITS(COORD_BITS)
    ) u_res_x (
        .clk   (clk),
        .coord (coord_x),
        .res   (res_x)
    );

    lpm_residue #(
        .COORD_BITS(COORD_BITS)
    ) u_res_y (
        .clk   (clk),
        .coord (coord_y),
        .res   (res_y)
    );

    lpm_residue #(
        .COORD_BITS(COORD_BITS)
    ) u_res_z (
        .clk   (clk),
        .coord (coord_z),
        .res   (res_z)
    );

    // lattice tests and result register
    lpm_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (v2_reg),
        .lat_type  (lat2_reg),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_z     (res_z),
        .sum_res   (sum2_reg),
        .done      (done),
        .is_member (is_member)
    );

    `ASSERT_DLY(a_accept_to_done, clk, rst_n, accept, 3, done)

endmodule

`default_nettype wire

FILE: verif/lattice_point_membership_tb.sv
// self-checking testbench for the lattice point membership pipeline
`timescale 1ns / 1ps

module lattice_point_membership_tb;

    localparam int          CB            = lpm_pkg::COORD_BITS_DEF;
    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 6;
    localparam int          TAIL_CYCLES   = 8;       // pipe is three stages deep
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          WORDS_PER_SET = 16;
    localparam int          SEARCH_TRIES  = 256;
    localparam int          NEAR_SPAN     = 100;
    localparam logic [3:0]  LAT_UNUSED_LO = 4'd12;   // selectors past k4 pick no lattice
    localparam logic [3:0]  LAT_UNUSED_HI = 4'd15;

    localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};

    // ------------------------------------------------------------------
    // expected membership bits, predicted from the point and lattice type
    // ------------------------------------------------------------------
    class member_scoreboard;
        logic [3:0] lattice_sel;
        bit         expected_member_q[$];
        int         fail_cnt;

        function new();
            lattice_sel = lpm_pkg::LAT_SC;
            fail_cnt    = 0;
        endfunction

        function void set_lattice(logic [3:0] sel);
            lattice_sel = sel;
        endfunction

        function longint abs64(longint a);
            return (a < 0) ? -a : a;
        endfunction

        // distance of |a| to the nearest multiple of six
        function longint fold_six(longint a);
            longint r;
            r = abs64(a) % 6;
            return (r > 3) ? 6 - r : r;
        endfunction

        function longint pos_mod4(longint a);
            return (a % 4 + 4) % 4;
        endfunction

        function bit hcp_member(longint x, longint y, longint z);
            longint m;
            longint n;
            m = x + y + z;
            n = (m < 0) ? 1 : 0;
            return (m % 6 == 0) && ((x - m / 12 + n) % 3 == 0) &&
                   ((y - m / 12 + n) % 3 == 0);
        endfunction

        function bit tr_oct_member(longint x, longint y, longint z);
            return (z % 4 == 0 && x % 4 != 0 && y % 4 != 0 && (x - y) % 2 != 0) ||
                   (y % 4 == 0 && z % 4 != 0 && x % 4 != 0 && (z - x) % 2 != 0) ||
                   (x % 4 == 0 && y % 4 != 0 && z % 4 != 0 && (y - z) % 2 != 0);
        endfunction

        function bit tr_tet_member(longint x, longint y, longint z);
            return (x % 2 == 0 && pos_mod4(y) == pos_mod4(x + z)) ||
                   (y % 2 == 0 && pos_mod4(z) == pos_mod4(y + x)) ||
                   (z % 2 == 0 && pos_mod4(x) == pos_mod4(z + y));
        endfunction

        function bit mixed_member(longint x, longint y, longint z);
            longint a;
            longint b;
            longint c;
            longint d;
            a = fold_six(x);
            b = fold_six(y);
            c = fold_six(z);
            d = a * a + b * b;
            return (c == 0 && (d == 2 || d == 8)) ||
                   (c == 1 && (d == 1 || d == 13)) ||
                   (c == 2 && (d == 4 || d == 10)) ||
                   (c == 3 && d == 5);
        endfunction

        function bit diamond_member(longint x, longint y, longint z);
            longint p;
            longint h;
            p = (x % 2 + 2) % 2 + (y % 2 + 2) % 2 + (z % 2 + 2) % 2;
            h = x / 2 + ((x % 2 < 0) ? 1 : 0) + y / 2 + ((y % 2 < 0) ? 1 : 0) +
                z / 2 + ((z % 2 < 0) ? 1 : 0);
            return (p % 3 == 0) && (h % 2 == 0);
        endfunction

        // four sublattice origins: x and z step by 3, y alternates 0 and 3
        function bit hcp_diamond_member(longint x, longint y, longint z);
            longint tx;
            longint ty;
            longint tz;
            longint s;
            longint e;
            for (int i = 0; i < 4; i++)
            begin
                tx = x - 3 * i;
                ty = y - 3 * (i % 2);
                tz = z - 3 * i;
                s  = tx + ty + tz;
                if (s % 24 == 0)
                begin
                    e = s / 3;
                    if ((tx - e) % 6 == 0 && (ty - e) % 6 == 0 && (tz - e) % 6 == 0)
                        return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        // negative coordinates get 4 added after truncation, so -4 lands on residue 4
        function bit k4_member(longint x, longint y, longint z);
            longint a;
            longint b;
            longint c;
            if ((x + y + z) % 2 != 0)
                return 1'b0;
            a = x % 4 + ((x < 0) ? 4 : 0);
            b = y % 4 + ((y < 0) ? 4 : 0);
            c = z % 4 + ((z < 0) ? 4 : 0);
            return (a == 0 && b == 0 && c == 0) || (a == 0 && b == 1 && c == 3) ||
                   (a == 1 && b == 0 && c == 1) || (a == 1 && b == 1 && c == 2) ||
                   (a == 2 && b == 2 && c == 2) || (a == 2 && b == 3 && c == 1) ||
                   (a == 3 && b == 2 && c == 3) || (a == 3 && b == 3 && c == 0);
        endfunction

        function bit predict_member(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                    logic signed [CB-1:0] pz);
            longint x;
            longint y;
            longint z;
            x = longint'(px);
            y = longint'(py);
            z = longint'(pz);
            case (lattice_sel)
                lpm_pkg::LAT_SC:          return 1'b1;
                lpm_pkg::LAT_FCC:         return (x + y + z) % 2 == 0;
                lpm_pkg::LAT_BCC:         return (x % 2 != 0 && y % 2 != 0 && z % 2 != 0) ||
                                                 (x % 2 == 0 && y % 2 == 0 && z % 2 == 0);
                lpm_pkg::LAT_HCP:         return hcp_member(x, y, z);
                lpm_pkg::LAT_RH_DODEC:    return (x % 2 != 0 && y % 2 != 0 && z % 2 != 0) ||
                                                 !(((x + y + z) / 2) % 2 == 0 ||
                                                   x % 2 != 0 || y % 2 != 0 || z % 2 != 0);
                lpm_pkg::LAT_CUBO_OCT:    return abs64(x) % 2 + abs64(y) % 2 +
                                                 abs64(z) % 2 == 2;
                lpm_pkg::LAT_TR_OCT:      return tr_oct_member(x, y, z);
                lpm_pkg::LAT_TR_TET:      return tr_tet_member(x, y, z);
                lpm_pkg::LAT_MIXED:       return mixed_member(x, y, z);
                lpm_pkg::LAT_DIAMOND:     return diamond_member(x, y, z);
                lpm_pkg::LAT_HCP_DIAMOND: return hcp_diamond_member(x, y, z);
                lpm_pkg::LAT_K4:          return k4_member(x, y, z);
                default:                  return 1'b0;
            endcase
        endfunction

        function void note_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                 logic signed [CB-1:0] pz);
            expected_member_q.push_back(predict_member(px, py, pz));
        endfunction

        function void check_result(logic got_member);
            bit want;
            if (expected_member_q.size() == 0)
            begin
                $error("is_member: result with no word outstanding, actual %0b", got_member);
                fail_cnt++;
                return;
            end
            want = expected_member_q.pop_front();
            if (got_member !== want)
            begin
                $error("is_member mismatch: expected %0b, actual %0b", want, got_member);
                fail_cnt++;
            end
        endfunction

        function int pending();
            return expected_member_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and the block's ports, the driven ones known from time zero
    // ------------------------------------------------------------------
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic signed [CB-1:0] coord_x     = '0;
    logic signed [CB-1:0] coord_y     = '0;
    logic signed [CB-1:0] coord_z     = '0;
    logic                 cfg_wr_en   = 1'b0;
    logic [3:0]           cfg_wr_data = '0;
    logic                 done;
    logic                 is_member;

    member_scoreboard board;
    int               idle_pct  = 0;
    int               cycle_cnt = 0;

    always #(HALF_PERIOD) clk = ~clk;

    lattice_point_membership #(
        .COORD_BITS (CB)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .is_member   (is_member)
    );

    // results cannot be held off: every done strobe is taken at the edge ending it
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(is_member);
    end

    // watchdog over the whole run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one word, idling at random first; start stays high into the next word
    task automatic send_point(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                              input logic signed [CB-1:0] z);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_point(x, y, z);
    endtask

    // small directed points given as plain integers
    task automatic send_int_point(input int x, input int y, input int z);
        send_point(CB'(x), CB'(y), CB'(z));
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // every word yields a result, so an empty scoreboard means the pipe is idle
    task automatic write_lattice(input logic [3:0] sel);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sel;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_lattice(sel);
    endtask

    function automatic logic signed [CB-1:0] near_coord();
        return CB'(int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN);
    endfunction

    function automatic logic signed [CB-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return CB'(COORD_MIN + 1);
            2:       return CB'(-1);
            3:       return '0;
            4:       return CB'(1);
            default: return COORD_MAX;
        endcase
    endfunction

    // mostly points on or near the lattice, the rest full-range and edge noise
    task automatic send_random_point();
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        int                   kind;
        int                   tries;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            // hunt for a member near the origin, negative quadrants included
            tries = 0;
            do
            begin
                x = near_coord();
                y = near_coord();
                z = near_coord();
                tries++;
            end
            while (!board.predict_member(x, y, z) && tries < SEARCH_TRIES);
        end
        else if (kind <= 5)
        begin
            x = near_coord();
            y = near_coord();
            z = near_coord();
        end
        else if (kind <= 8)
        begin
            x = CB'($urandom);
            y = CB'($urandom);
            z = CB'($urandom);
        end
        else
        begin
            x = edge_coord();
            y = edge_coord();
            z = edge_coord();
        end
        send_point(x, y, z);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset value first, simple cubic at the coordinate extremes
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_int_point(0, 0, 0);
        send_point(COORD_MIN, COORD_MAX, CB'(-1));

        write_lattice(lpm_pkg::LAT_FCC);
        send_point(COORD_MAX, COORD_MAX, COORD_MIN);
        send_int_point(1, 0, 0);

        // negative multiples of four map to residue four and miss every pattern
        write_lattice(lpm_pkg::LAT_K4);
        send_int_point(-4, -4, -4);
        send_int_point(0, 0, 0);
        send_int_point(-3, -3, -2);

        // negative coordinate sum takes the add-one correction after m / 12
        write_lattice(lpm_pkg::LAT_HCP);
        send_int_point(-1, -1, -4);
        send_int_point(-6, 0, 0);
        send_int_point(0, 0, 0);

        // includes the squared distance 13 case
        write_lattice(lpm_pkg::LAT_MIXED);
        send_int_point(2, 3, 1);
        send_int_point(1, 1, 0);
        send_int_point(-4, -3, -1);

        write_lattice(lpm_pkg::LAT_HCP_DIAMOND);
        send_int_point(3, 3, 3);
        send_int_point(9, 3, 9);
        send_int_point(-8, -8, -8);

        write_lattice(lpm_pkg::LAT_DIAMOND);
        send_int_point(1, 1, 1);
        send_int_point(-1, -1, -1);

        // selectors with no lattice answer 0 everywhere
        write_lattice(LAT_UNUSED_LO);
        send_int_point(0, 0, 0);
        write_lattice(LAT_UNUSED_HI);
        send_int_point(1, 1, 1);

        // random: light idling, heavy idling, then back to back
        for (int mode = 0; mode < 3; mode++)
        begin
            idle_pct = (mode == 0) ? 8 : ((mode == 1) ? 50 : 0);
            for (int t = 0; t < 16; t++)
            begin
                write_lattice((mode == 1) ? 4'(15 - t) : 4'(t));
                repeat (WORDS_PER_SET) send_random_point();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.fail_cnt == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
